// ===== sv/nmea_gga_position_extractor_assert.svh =====
// Assertion macros shared by the position extractor RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef NMEA_GGA_POSITION_EXTRACTOR_ASSERT_SVH
`define NMEA_GGA_POSITION_EXTRACTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/nmeagga_pkg.sv =====
// ----------------------------------------------------------------------------
// nmeagga_pkg
// Characters, field indexes, lengths and scaling constants for the GGA
// latitude and longitude extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package nmeagga_pkg;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    // Comma-separated field indexes within the sentence.
    localparam logic [3:0] FIELD_LAT     = 4'd2;
    localparam logic [3:0] FIELD_LAT_DIR = 4'd3;
    localparam logic [3:0] FIELD_LON     = 4'd4;
    localparam logic [3:0] FIELD_LON_DIR = 4'd5;
    localparam logic [3:0] FIELD_DONE    = 4'd6;
    localparam logic [3:0] COUNT_MAX     = 4'd15;

    // Required field lengths and positions inside the coordinate fields.
    localparam logic [3:0] LAT_LEN     = 4'd9;
    localparam logic [3:0] LON_LEN     = 4'd10;
    localparam logic [3:0] DIR_LEN     = 4'd1;
    localparam logic [3:0] LAT_DEG_LEN = 4'd2;
    localparam logic [3:0] LON_DEG_LEN = 4'd3;
    localparam logic [3:0] LAT_DOT_POS = 4'd4;
    localparam logic [3:0] LON_DOT_POS = 4'd5;
    localparam logic [3:0] LAT_END_POS = 4'd8;
    localparam logic [3:0] LON_END_POS = 4'd9;

    // Degrees are scaled by 1e7. Minutes in 1e-4 units become 1e-7 degree
    // through floor(m * 50 / 3), done as m * 50 * ceil(2^28 / 3) >> 28.
    localparam logic [23:0] DEG_SCALE   = 24'd10000000;
    localparam logic [32:0] MIN_RECIP   = 33'd4473924300;
    localparam int          RECIP_SHIFT = 28;
    localparam logic [19:0] MIN_LIMIT   = 20'd600000;
    localparam logic [30:0] LAT_MAX     = 31'd900000000;
    localparam logic [33:0] LON_MAX     = 34'd1800000000;

    typedef logic [6:0]  t_lat_deg;
    typedef logic [9:0]  t_lon_deg;
    typedef logic [19:0] t_min_e4;

endpackage

`default_nettype wire

// ===== sv/nmea_gga_position_extractor.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_position_extractor
// Parses the latitude and longitude fields of a GGA sentence, one byte per
// beat, and returns signed degrees in 1e-7 units when the sentence ends.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  bytes   | in        | i_in_valid / o_in_stall  | i_char_in, i_end_of_sentence
//  result  | out       | o_out_valid / i_out_stall| o_latitude, o_longitude,
//          |           |                          | o_valid_res
//
//  One byte is accepted per cycle while o_in_stall is low. The parse
//  registers update on the beat itself; after the last byte, the result passes
//  through the four-stage arithmetic pipeline (snapshot, multiply, add and range check, sign).
//  Synchronous active-low reset clears the parse state and all stage valids.
//  Each stage holds while the one after it is full and stalled, so empty
//  stages fill up before the input side is stalled.
`default_nettype none

module nmea_gga_position_extractor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_end_of_sentence,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [30:0]      o_latitude,
    output logic [31:0]      o_longitude,
    output logic             o_valid_res
);
    import nmeagga_pkg::*;

    // Parse state.
    logic [3:0] r_field_count, n_field_count;
    logic [3:0] r_char_pos,    n_char_pos;
    t_lat_deg   r_lat_deg,     n_lat_deg;
    t_min_e4    r_lat_min,     n_lat_min;
    logic       r_lat_south,   n_lat_south;
    t_lon_deg   r_lon_deg,     n_lon_deg;
    t_min_e4    r_lon_min,     n_lon_min;
    logic       r_lon_west,    n_lon_west;
    logic       r_fmt_err,     n_fmt_err;

    // Pipeline stages.
    logic       r_va, r_vb, r_vc, r_vd;
    logic       en_a, en_b, en_c, en_d;
    logic       accept;

    t_lat_deg   r_a_lat_deg;
    t_lon_deg   r_a_lon_deg;
    t_min_e4    r_a_lat_min, r_a_lon_min;
    logic       r_a_south, r_a_west, r_a_ok;
    logic       n_a_ok;

    logic [30:0] r_b_lat_dp;
    logic [33:0] r_b_lon_dp;
    logic [24:0] r_b_lat_mp, r_b_lon_mp;
    logic        r_b_south, r_b_west, r_b_ok;
    logic [52:0] lat_min_prod, lon_min_prod;

    logic [30:0] r_c_lat_mag;
    logic [31:0] r_c_lon_mag;
    logic        r_c_south, r_c_west, r_c_ok;
    logic [30:0] lat_mag;
    logic [33:0] lon_mag;

    logic [30:0] r_lat_out;
    logic [31:0] r_lon_out;
    logic        r_ok_out;

    // Closing a field with the wrong byte count flags a format error.
    function automatic logic close_bad(input logic [3:0] fc, input logic [3:0] pos);
        logic [3:0] need;
        unique case (fc)
            FIELD_LAT:     need = LAT_LEN;
            FIELD_LAT_DIR: need = DIR_LEN;
            FIELD_LON:     need = LON_LEN;
            FIELD_LON_DIR: need = DIR_LEN;
            default:       need = pos;
        endcase
        return pos != need;
    endfunction

    function automatic logic [3:0] sat_inc(input logic [3:0] v);
        return (v < COUNT_MAX) ? 4'(v + 4'd1) : v;
    endfunction

    assign en_d       = !r_vd || !i_out_stall;
    assign en_c       = !r_vc || en_d;
    assign en_b       = !r_vb || en_c;
    assign en_a       = !r_va || en_b;
    assign o_in_stall = !en_a;
    assign accept     = i_in_valid && en_a;

    always_comb begin
        logic       is_comma;
        logic       is_digit;
        logic [3:0] digit;
        logic [3:0] fc2;
        logic       fe2;

        is_comma = (i_char_in == CHAR_COMMA);
        is_digit = (i_char_in >= CHAR_ZERO) && (i_char_in <= CHAR_NINE);
        digit    = 4'(i_char_in - CHAR_ZERO);

        n_field_count = r_field_count;
        n_char_pos    = r_char_pos;
        n_lat_deg     = r_lat_deg;
        n_lat_min     = r_lat_min;
        n_lat_south   = r_lat_south;
        n_lon_deg     = r_lon_deg;
        n_lon_min     = r_lon_min;
        n_lon_west    = r_lon_west;
        n_fmt_err     = r_fmt_err;

        if (is_comma) begin
            if (close_bad(r_field_count, r_char_pos)) begin
                n_fmt_err = 1'b1;
            end
            n_field_count = sat_inc(r_field_count);
            n_char_pos    = 4'd0;
        end else begin
            unique case (r_field_count)
                FIELD_LAT: begin
                    if (r_char_pos > LAT_END_POS) begin
                        n_fmt_err = 1'b1;
                    end else if (r_char_pos == LAT_DOT_POS) begin
                        if (i_char_in != CHAR_DOT) n_fmt_err = 1'b1;
                    end else if (!is_digit) begin
                        n_fmt_err = 1'b1;
                    end else if (r_char_pos < LAT_DEG_LEN) begin
                        n_lat_deg = 7'(r_lat_deg * 7'd10 + 7'(digit));
                    end else begin
                        n_lat_min = 20'(r_lat_min * 20'd10 + 20'(digit));
                    end
                end
                FIELD_LAT_DIR: begin
                    if (r_char_pos != 4'd0) n_fmt_err = 1'b1;
                    else n_lat_south = (i_char_in == CHAR_S);
                end
                FIELD_LON: begin
                    if (r_char_pos > LON_END_POS) begin
                        n_fmt_err = 1'b1;
                    end else if (r_char_pos == LON_DOT_POS) begin
                        if (i_char_in != CHAR_DOT) n_fmt_err = 1'b1;
                    end else if (!is_digit) begin
                        n_fmt_err = 1'b1;
                    end else if (r_char_pos < LON_DEG_LEN) begin
                        n_lon_deg = 10'(r_lon_deg * 10'd10 + 10'(digit));
                    end else begin
                        n_lon_min = 20'(r_lon_min * 20'd10 + 20'(digit));
                    end
                end
                FIELD_LON_DIR: begin
                    if (r_char_pos != 4'd0) n_fmt_err = 1'b1;
                    else n_lon_west = (i_char_in == CHAR_W);
                end
                default: begin
                end
            endcase
            n_char_pos = sat_inc(r_char_pos);
        end

        // At sentence end a field still open is closed as well.
        fc2 = n_field_count;
        fe2 = n_fmt_err;
        if (!is_comma) begin
            if (close_bad(n_field_count, n_char_pos)) fe2 = 1'b1;
            fc2 = sat_inc(n_field_count);
        end
        n_a_ok = !fe2 && (fc2 >= FIELD_DONE)
              && (n_lat_min < MIN_LIMIT) && (n_lon_min < MIN_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= '0;
            r_char_pos    <= '0;
            r_lat_deg     <= '0;
            r_lat_min     <= '0;
            r_lat_south   <= 1'b0;
            r_lon_deg     <= '0;
            r_lon_min     <= '0;
            r_lon_west    <= 1'b0;
            r_fmt_err     <= 1'b0;
        end else if (accept) begin
            if (i_end_of_sentence) begin
                r_field_count <= '0;
                r_char_pos    <= '0;
                r_lat_deg     <= '0;
                r_lat_min     <= '0;
                r_lat_south   <= 1'b0;
                r_lon_deg     <= '0;
                r_lon_min     <= '0;
                r_lon_west    <= 1'b0;
                r_fmt_err     <= 1'b0;
            end else begin
                r_field_count <= n_field_count;
                r_char_pos    <= n_char_pos;
                r_lat_deg     <= n_lat_deg;
                r_lat_min     <= n_lat_min;
                r_lat_south   <= n_lat_south;
                r_lon_deg     <= n_lon_deg;
                r_lon_min     <= n_lon_min;
                r_lon_west    <= n_lon_west;
                r_fmt_err     <= n_fmt_err;
            end
        end
    end

    assign lat_min_prod = 53'(r_a_lat_min) * 53'(MIN_RECIP);
    assign lon_min_prod = 53'(r_a_lon_min) * 53'(MIN_RECIP);
    assign lat_mag      = r_b_lat_dp + 31'(r_b_lat_mp);
    assign lon_mag      = r_b_lon_dp + 34'(r_b_lon_mp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_a) r_va <= accept && i_end_of_sentence;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_lat_deg <= n_lat_deg;
            r_a_lat_min <= n_lat_min;
            r_a_south   <= n_lat_south;
            r_a_lon_deg <= n_lon_deg;
            r_a_lon_min <= n_lon_min;
            r_a_west    <= n_lon_west;
            r_a_ok      <= n_a_ok;
        end
        if (en_b) begin
            r_b_lat_dp <= 31'(r_a_lat_deg) * 31'(DEG_SCALE);
            r_b_lon_dp <= 34'(r_a_lon_deg) * 34'(DEG_SCALE);
            r_b_lat_mp <= lat_min_prod[52:RECIP_SHIFT];
            r_b_lon_mp <= lon_min_prod[52:RECIP_SHIFT];
            r_b_south  <= r_a_south;
            r_b_west   <= r_a_west;
            r_b_ok     <= r_a_ok;
        end
        if (en_c) begin
            r_c_lat_mag <= lat_mag;
            r_c_lon_mag <= lon_mag[31:0];
            r_c_south   <= r_b_south;
            r_c_west    <= r_b_west;
            r_c_ok      <= r_b_ok && (lat_mag <= LAT_MAX) && (lon_mag <= LON_MAX);
        end
        if (en_d) begin
            r_ok_out <= r_c_ok;
            if (!r_c_ok) begin
                r_lat_out <= '0;
                r_lon_out <= '0;
            end else begin
                r_lat_out <= r_c_south ? 31'(-r_c_lat_mag) : r_c_lat_mag;
                r_lon_out <= r_c_west  ? 32'(-r_c_lon_mag) : r_c_lon_mag;
            end
        end
    end

    assign o_out_valid = r_vd;
    assign o_latitude  = r_lat_out;
    assign o_longitude = r_lon_out;
    assign o_valid_res = r_ok_out;

`include "nmea_gga_position_extractor_assert.svh"

    `NGE_ASSERT_SAME(a_invalid_is_zero, o_out_valid && !o_valid_res, (o_latitude == 31'd0) && (o_longitude == 32'd0), "invalid result carries nonzero coordinates")
    `NGE_ASSERT_SAME(a_lat_in_range, o_out_valid && o_valid_res, ($signed(o_latitude) <= 31'sd900000000) && ($signed(o_latitude) >= -31'sd900000000), "valid latitude out of range")
    `NGE_ASSERT_NEXT(a_eos_enters_pipe, i_in_valid && !o_in_stall && i_end_of_sentence, r_va && (r_field_count == 4'd0) && (r_char_pos == 4'd0), "sentence end did not load the snapshot stage")

endmodule

`default_nettype wire

// ===== sim/gga_fix_checker.sv =====
// ----------------------------------------------------------------------------
// gga_fix_checker
// Watches the byte and result channels of the GGA position extractor, keeps
// its own parse of every accepted byte, and compares each result beat with
// the oldest predicted fix.
// ----------------------------------------------------------------------------

module gga_fix_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_sentence,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [30:0] i_latitude,
    input  logic [31:0] i_longitude,
    input  logic        i_valid_res,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import nmeagga_pkg::*;

    typedef struct packed {
        logic [30:0] lat;
        logic [31:0] lon;
        logic        ok;
    } t_fix;

    t_fix expected_fixes[$];
    int   fail_total    = 0;
    int   pending_total = 0;

    // Parse state of the sentence in flight.
    logic [3:0] field_idx   = '0;
    logic [3:0] field_pos   = '0;
    t_lat_deg   lat_deg     = '0;
    t_min_e4    lat_min     = '0;
    logic       lat_south   = 1'b0;
    t_lon_deg   lon_deg     = '0;
    t_min_e4    lon_min     = '0;
    logic       lon_west    = 1'b0;
    logic       bad_format  = 1'b0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task clear_parse();
        field_idx  = '0;
        field_pos  = '0;
        lat_deg    = '0;
        lat_min    = '0;
        lat_south  = 1'b0;
        lon_deg    = '0;
        lon_min    = '0;
        lon_west   = 1'b0;
        bad_format = 1'b0;
    endtask

    function logic is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function logic coord_bad(input logic [7:0] c, input logic [3:0] pos,
                             input logic [3:0] dot_pos, input logic [3:0] end_pos);
        if (pos > end_pos) begin
            return 1'b1;
        end
        if (pos == dot_pos) begin
            return c != CHAR_DOT;
        end
        return !is_digit(c);
    endfunction

    task take_byte(input logic [7:0] c);
        logic [3:0]  digit;
        logic [31:0] acc;
        digit = c[3:0];
        case (field_idx)
            FIELD_LAT: begin
                if (coord_bad(c, field_pos, LAT_DOT_POS, LAT_END_POS)) begin
                    bad_format = 1'b1;
                end else if (field_pos < LAT_DEG_LEN) begin
                    acc     = {25'd0, lat_deg} * 32'd10 + {28'd0, digit};
                    lat_deg = acc[6:0];
                end else if (field_pos != LAT_DOT_POS) begin
                    acc     = {12'd0, lat_min} * 32'd10 + {28'd0, digit};
                    lat_min = acc[19:0];
                end
            end
            FIELD_LAT_DIR: begin
                if (field_pos != 4'd0) begin
                    bad_format = 1'b1;
                end else begin
                    lat_south = (c == CHAR_S);
                end
            end
            FIELD_LON: begin
                if (coord_bad(c, field_pos, LON_DOT_POS, LON_END_POS)) begin
                    bad_format = 1'b1;
                end else if (field_pos < LON_DEG_LEN) begin
                    acc     = {22'd0, lon_deg} * 32'd10 + {28'd0, digit};
                    lon_deg = acc[9:0];
                end else if (field_pos != LON_DOT_POS) begin
                    acc     = {12'd0, lon_min} * 32'd10 + {28'd0, digit};
                    lon_min = acc[19:0];
                end
            end
            FIELD_LON_DIR: begin
                if (field_pos != 4'd0) begin
                    bad_format = 1'b1;
                end else begin
                    lon_west = (c == CHAR_W);
                end
            end
            default: begin
            end
        endcase
        if (field_pos != COUNT_MAX) begin
            field_pos = field_pos + 4'd1;
        end
    endtask

    task close_field();
        logic [3:0] need;
        case (field_idx)
            FIELD_LAT:                    need = LAT_LEN;
            FIELD_LON:                    need = LON_LEN;
            FIELD_LAT_DIR, FIELD_LON_DIR: need = DIR_LEN;
            default:                      need = field_pos;
        endcase
        if (field_pos != need) begin
            bad_format = 1'b1;
        end
        if (field_idx != COUNT_MAX) begin
            field_idx = field_idx + 4'd1;
        end
        field_pos = '0;
    endtask

    // Feeds one accepted byte into the parse; the last byte of a sentence
    // closes the open field and queues the fix the block must return.
    task predict_beat(input logic [7:0] c, input logic last);
        logic [63:0] lat_mag;
        logic [63:0] lon_mag;
        logic [63:0] signed_val;
        t_fix        fix;
        if (c == CHAR_COMMA) begin
            close_field();
        end else begin
            take_byte(c);
        end
        if (last) begin
            if (c != CHAR_COMMA) begin
                close_field();
            end
            lat_mag = {57'd0, lat_deg} * {40'd0, DEG_SCALE}
                    + {44'd0, lat_min} * 64'd50 / 64'd3;
            lon_mag = {54'd0, lon_deg} * {40'd0, DEG_SCALE}
                    + {44'd0, lon_min} * 64'd50 / 64'd3;
            fix.ok = !bad_format && field_idx >= FIELD_DONE
                  && lat_min < MIN_LIMIT && lon_min < MIN_LIMIT
                  && lat_mag <= {33'd0, LAT_MAX} && lon_mag <= {30'd0, LON_MAX};
            fix.lat = '0;
            fix.lon = '0;
            if (fix.ok) begin
                signed_val = lat_south ? 64'd0 - lat_mag : lat_mag;
                fix.lat    = signed_val[30:0];
                signed_val = lon_west ? 64'd0 - lon_mag : lon_mag;
                fix.lon    = signed_val[31:0];
            end
            expected_fixes.push_back(fix);
            clear_parse();
        end
    endtask

    task check_fix();
        t_fix want;
        if (expected_fixes.size() == 0) begin
            $error("result beat with no fix pending: latitude %0d longitude %0d valid %0b",
                   $signed(i_latitude), $signed(i_longitude), i_valid_res);
            fail_total++;
        end else begin
            want = expected_fixes.pop_front();
            if (i_latitude !== want.lat) begin
                $error("latitude: expected %0d, actual %0d",
                       $signed(want.lat), $signed(i_latitude));
                fail_total++;
            end
            if (i_longitude !== want.lon) begin
                $error("longitude: expected %0d, actual %0d",
                       $signed(want.lon), $signed(i_longitude));
                fail_total++;
            end
            if (i_valid_res !== want.ok) begin
                $error("valid_res: expected %0b, actual %0b", want.ok, i_valid_res);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            expected_fixes.delete();
        end else begin
            // Check before predicting so a stray result never meets a fix
            // queued in the same cycle.
            if (i_out_valid && !i_out_stall) begin
                check_fix();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_char_in, i_end_of_sentence);
            end
        end
        pending_total = expected_fixes.size();
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives GGA sentences into the position extractor: a directed set of edge
// cases, then random well-formed, corrupted and noise sentences, with bursty
// byte traffic and a stalling receiver. The checker beside the block judges
// every result.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nmeagga_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int BYTE_TARGET  = 1900;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] CHAR_N = 8'h4E;
    localparam logic [7:0] CHAR_E = 8'h45;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} t_stall_mode;
    typedef enum {EDIT_REPLACE, EDIT_DROP, EDIT_INSERT, EDIT_TRUNCATE} t_edit_kind;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_in   = 8'd0;
    logic        eos       = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] latitude;
    logic [31:0] longitude;
    logic        valid_res;
    int          fail_count;
    int          pending;

    logic [7:0]  line_q[$];
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    int          gap_pct     = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    nmea_gga_position_extractor i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_char_in         (char_in),
        .i_end_of_sentence (eos),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_latitude        (latitude),
        .o_longitude       (longitude),
        .o_valid_res       (valid_res)
    );

    gga_fix_checker i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_char_in         (char_in),
        .i_end_of_sentence (eos),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_latitude        (latitude),
        .i_longitude       (longitude),
        .i_valid_res       (valid_res),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(1, 60);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= 1'b1;
        endcase
    end

    // Presents one byte at the falling edge and holds it until a rising
    // edge takes the beat.
    task put_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 99) < gap_pct) begin
                gap = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid <= 1'b1;
        char_in  <= c;
        eos      <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task send_line();
        int i;
        if (line_q.size() == 0) begin
            line_q.push_back(CHAR_COMMA);
        end
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
        for (i = 0; i < line_q.size(); i++) begin
            put_byte(line_q[i], i == line_q.size() - 1);
        end
        line_q.delete();
    endtask

    task add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            line_q.push_back(s[i]);
        end
    endtask

    task add_num(input int value, input int digits);
        int i;
        int p;
        p = 1;
        for (i = 1; i < digits; i++) p = p * 10;
        for (i = 0; i < digits; i++) begin
            line_q.push_back(CHAR_ZERO + 8'((value / p) % 10));
            p = p / 10;
        end
    endtask

    task add_coord(input int deg, input int deg_digits, input int min_e4);
        add_num(deg, deg_digits);
        add_num(min_e4 / 10000, 2);
        line_q.push_back(CHAR_DOT);
        add_num(min_e4 % 10000, 4);
    endtask

    task add_dir(input logic [7:0] neg_char, input logic [7:0] pos_char);
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0, 1:    c = neg_char;
            2, 3:    c = pos_char;
            default: c = 8'($urandom_range(0, 255));
        endcase
        if (c == CHAR_COMMA) begin
            c = pos_char;
        end
        line_q.push_back(c);
    endtask

    function int pick_minutes();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 599999;
            2:       return $urandom_range(600000, 999999);
            default: return $urandom_range(0, 599999);
        endcase
    endfunction

    function int pick_degrees(input int top, input int widest);
        case ($urandom_range(0, 7))
            0:       return top;
            1:       return top - 1;
            2:       return 0;
            3:       return $urandom_range(top + 1, widest);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task build_good();
        int n;
        n = $urandom_range(0, 6);
        repeat (n) line_q.push_back(8'($urandom_range(65, 90)));
        line_q.push_back(CHAR_COMMA);
        n = $urandom_range(0, 9);
        repeat (n) line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        line_q.push_back(CHAR_COMMA);
        add_coord(pick_degrees(90, 99), 2, pick_minutes());
        line_q.push_back(CHAR_COMMA);
        add_dir(CHAR_S, CHAR_N);
        line_q.push_back(CHAR_COMMA);
        add_coord(pick_degrees(180, 999), 3, pick_minutes());
        line_q.push_back(CHAR_COMMA);
        add_dir(CHAR_W, CHAR_E);
        case ($urandom_range(0, 3))
            0: begin
                // The sentence ends on the direction byte.
            end
            1: line_q.push_back(CHAR_COMMA);
            default: begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    line_q.push_back(CHAR_COMMA);
                    repeat ($urandom_range(0, 3)) begin
                        line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
            end
        endcase
    endtask

    task corrupt_line();
        int         n;
        int         idx;
        t_edit_kind kind;
        n = $urandom_range(1, 2);
        repeat (n) begin
            kind = t_edit_kind'($urandom_range(0, 3));
            idx  = $urandom_range(0, line_q.size() - 1);
            case (kind)
                EDIT_REPLACE: line_q[idx] = 8'($urandom_range(0, 255));
                EDIT_DROP: begin
                    if (line_q.size() > 1) begin
                        line_q.delete(idx);
                    end
                end
                EDIT_INSERT: line_q.insert(idx, 8'($urandom_range(0, 255)));
                default: begin
                    while (line_q.size() > idx + 1) line_q.delete(line_q.size() - 1);
                end
            endcase
        end
    endtask

    task build_noise();
        int n;
        n = $urandom_range(1, 40);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                line_q.push_back(CHAR_COMMA);
            end else begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task run_directed();
        add_text("$GPGGA,123519,4807.0380,N,01131.0000,E,1,08,0.9,545.4,M,46.9,M,,*47");
        send_line();
        add_text(",,0000.0000,N,00000.0000,E");
        send_line();
        // Both magnitudes at their limits, ending on a comma.
        add_text("$GNGGA,,9000.0000,S,18000.0000,W,");
        send_line();
        add_text(",,8959.9999,S,17959.9999,W,1");
        send_line();
        add_text(",,9000.0001,N,00000.0000,E");
        send_line();
        add_text(",,0000.0000,S,18000.0001,W");
        send_line();
        add_text(",,1260.0000,N,01200.0000,E");
        send_line();
        add_text(",,1200.0000,N,01260.0000,E");
        send_line();
        add_text(",,9959.9999,N,99959.9999,W");
        send_line();
        // Sentence ends before the east/west field exists.
        add_text(",,4807.0380,N,01131.0000");
        send_line();
        add_text(",,4807.0380,,01131.0000,E");
        send_line();
        add_text(",,4807.0380,NN,01131.0000,E");
        send_line();
        add_text(",,4807x0380,N,01131.0000,E");
        send_line();
        add_text(",,4A07.0380,N,01131.0000,E");
        send_line();
        add_text(",,4807.038,N,01131.0000,E");
        send_line();
        add_text(",,4807.03801,N,01131.00000,E");
        send_line();
        // Lowercase letters count as north and east.
        add_text(",,4807.0380,s,01131.0000,w");
        send_line();
        add_text(",,4807.0380,S,01131.0000,E,,,,,,,,,,,,,,,,,,,");
        send_line();
        add_text("GPGGAGPGGAGPGGAGPGGA,,48070380480703804807,N,01131.0000,E");
        send_line();
        add_text(",");
        send_line();
        line_q.push_back(8'hFF);
        send_line();
        add_text(",,,,,,");
        send_line();
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int pick;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (bytes_sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                build_good();
            end else if (pick < 85) begin
                build_good();
                corrupt_line();
            end else begin
                build_noise();
            end
            send_line();
        end
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
